// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared constants and types for the per-source sequence loss tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Table depth and derived widths
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned NUM_W   = 8;
  localparam int unsigned FRAME_W = 16;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Write request into the source table
  typedef struct packed {
    logic              addr_we;
    logic              num_we;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [NUM_W-1:0]  num;
  } pst_wr_t;

endpackage

// File: sv/pst_table.sv
// ----------------------------------------------------------------------------
// pst_table
// Source table storage: address and packet number per entry, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module pst_table (
  input  logic                           clk_i,
  input  pst_pkg::pst_wr_t               wr_i,
  input  logic [pst_pkg::IDX_W-1:0]      rd_idx_i,
  output logic [pst_pkg::ADDR_W-1:0]     rd_addr_o,
  output logic [pst_pkg::NUM_W-1:0]      rd_num_o
);
  import pst_pkg::*;

  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [NUM_W-1:0]  num_mem  [ENTRIES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.addr_we) begin
      addr_mem[wr_i.idx] <= wr_i.addr;
    end
    if (wr_i.num_we) begin
      num_mem[wr_i.idx] <= wr_i.num;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_addr_o <= addr_mem[rd_idx_i];
    rd_num_o  <= num_mem[rd_idx_i];
  end

endmodule

// File: sv/per_source_sequence_loss_tracker.sv
// ----------------------------------------------------------------------------
// per_source_sequence_loss_tracker
// Tracks the newest packet number per source and reports missed packets
// revealed by beacon entries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The block then scans
// its source table one entry per cycle through a table with one registered
// read port, comparing each read as the next is issued, and then decides and
// writes back in a separate decide state, which also loads the result
// registers. The scan stops at the first match or after the last stored entry.
// busy drops in the result cycle, so the next command can be taken at the edge
// that ends it. Exactly one result is presented on done_o for one cycle per
// command; the receiver must take it in that cycle, since results cannot be
// held off.
module per_source_sequence_loss_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [pst_pkg::ADDR_W-1:0]    source_addr_i,
  input  logic [pst_pkg::ADDR_W-1:0]    peer_addr_i,
  input  logic [pst_pkg::NUM_W-1:0]     packet_number_i,
  input  logic                          link_qualifies_i,
  input  logic [pst_pkg::FRAME_W-1:0]   frame_number_i,
  output logic                          done_o,
  output logic                          peer_known_o,
  output logic                          table_full_o,
  output logic                          number_advanced_o,
  output logic                          loss_found_o,
  output logic [pst_pkg::ADDR_W-1:0]    reporter_addr_o,
  output logic [pst_pkg::ADDR_W-1:0]    lost_from_addr_o,
  output logic [pst_pkg::NUM_W-1:0]     missed_number_o,
  output logic [pst_pkg::FRAME_W-1:0]   report_frame_o
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             found_q, found_d;
  logic             done_q, done_d;

  // Payload registers
  logic               cmd_q;
  logic [ADDR_W-1:0]  src_q;
  logic [ADDR_W-1:0]  peer_q;
  logic [NUM_W-1:0]   num_q;
  logic               link_q;
  logic [FRAME_W-1:0] frame_q;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [NUM_W-1:0]   hit_num_q, hit_num_d;

  logic               known_q, full_q, adv_q, loss_q;
  logic [ADDR_W-1:0]  rep_q, lost_q;
  logic [NUM_W-1:0]   miss_q;
  logic [FRAME_W-1:0] rframe_q;

  logic [ADDR_W-1:0]  rd_addr;
  logic [NUM_W-1:0]   rd_num;
  logic [ADDR_W-1:0]  key;
  logic               issue_en;
  logic               match;
  logic               accept;
  pst_wr_t            wr;

  // Decision terms
  logic [NUM_W-1:0]   diff;
  logic               ahead;
  logic               room;
  logic               loss;

  assign accept   = start && (state_q == ST_IDLE);
  assign key      = (cmd_q == CMD_CHECK) ? peer_q : src_q;
  assign issue_en = (scan_q < count_q);
  assign match    = pend_q && (rd_addr == key);

  assign diff  = num_q - hit_num_q;
  assign ahead = (diff != '0) && !diff[NUM_W-1];
  assign room  = (count_q < CNT_W'(ENTRIES));
  assign loss  = found_q && (peer_q != src_q) && link_q && (num_q != hit_num_q);

  pst_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_idx_i  (scan_q[IDX_W-1:0]),
    .rd_addr_o (rd_addr),
    .rd_num_o  (rd_num)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    done_d     = 1'b0;
    hit_idx_d  = hit_idx_q;
    hit_num_d  = hit_num_q;
    wr         = '0;
    wr.idx     = hit_idx_q;
    wr.addr    = src_q;
    wr.num     = num_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
          scan_d  = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the previous read
        if (issue_en) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
          scan_d     = scan_q + CNT_W'(1);
        end
        if (match) begin
          found_d   = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_num_d = rd_num;
          pend_d    = 1'b0;
          state_d   = ST_DECIDE;
        end else if (!pend_q && !issue_en) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_UPDATE) begin
          if (found_q) begin
            wr.num_we = ahead;
          end else if (room) begin
            wr.addr_we = 1'b1;
            wr.num_we  = 1'b1;
            wr.idx     = count_q[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  // Command capture and scan payload
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_num_q  <= hit_num_d;
    if (accept) begin
      cmd_q   <= command_i;
      src_q   <= source_addr_i;
      peer_q  <= peer_addr_i;
      num_q   <= packet_number_i;
      link_q  <= link_qualifies_i;
      frame_q <= frame_number_i;
    end
  end

  // Result register, loaded as the command finishes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      known_q  <= found_q;
      full_q   <= (cmd_q == CMD_UPDATE) && !found_q && !room;
      adv_q    <= (cmd_q == CMD_UPDATE) && (found_q ? ahead : room);
      loss_q   <= (cmd_q == CMD_CHECK) && loss;
      rep_q    <= ((cmd_q == CMD_CHECK) && loss) ? src_q : '0;
      lost_q   <= ((cmd_q == CMD_CHECK) && loss) ? peer_q : '0;
      miss_q   <= ((cmd_q == CMD_CHECK) && loss) ? num_q + NUM_W'(1) : '0;
      rframe_q <= ((cmd_q == CMD_CHECK) && loss) ? frame_q : '0;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign peer_known_o      = known_q;
  assign table_full_o      = full_q;
  assign number_advanced_o = adv_q;
  assign loss_found_o      = loss_q;
  assign reporter_addr_o   = rep_q;
  assign lost_from_addr_o  = lost_q;
  assign missed_number_o   = miss_q;
  assign report_frame_o    = rframe_q;

endmodule

// File: tb/per_source_sequence_loss_tracker_test.sv
// ----------------------------------------------------------------------------
// per_source_sequence_loss_tracker_test
// Self-checking bench for the per-source sequence loss tracker. A directed
// set covers serial-number wrap, stale and equal updates, and every reason a
// beacon check skips a loss report. Random traffic then runs over a small pool
// of sources, so the table fills up and further new sources are dropped. Each
// result is checked against an in-bench model of the source table.
// ----------------------------------------------------------------------------
module per_source_sequence_loss_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int unsigned POOL       = 24;
  localparam int unsigned RAND_ITEMS = 1800;
  localparam int unsigned CALM_TAIL  = 200;
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct packed {
    logic               command;
    logic [ADDR_W-1:0]  source_addr;
    logic [ADDR_W-1:0]  peer_addr;
    logic [NUM_W-1:0]   number;
    logic               link;
    logic [FRAME_W-1:0] frame;
  } tracker_cmd_t;

  typedef struct packed {
    logic               known;
    logic               full;
    logic               advanced;
    logic               loss;
    logic [ADDR_W-1:0]  reporter;
    logic [ADDR_W-1:0]  lost_from;
    logic [NUM_W-1:0]   missed;
    logic [FRAME_W-1:0] frame;
  } loss_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                command_i = CMD_UPDATE;
  logic [ADDR_W-1:0]   source_addr_i = '0;
  logic [ADDR_W-1:0]   peer_addr_i = '0;
  logic [NUM_W-1:0]    packet_number_i = '0;
  logic                link_qualifies_i = 1'b0;
  logic [FRAME_W-1:0]  frame_number_i = '0;
  logic                done_o;
  logic                peer_known_o;
  logic                table_full_o;
  logic                number_advanced_o;
  logic                loss_found_o;
  logic [ADDR_W-1:0]   reporter_addr_o;
  logic [ADDR_W-1:0]   lost_from_addr_o;
  logic [NUM_W-1:0]    missed_number_o;
  logic [FRAME_W-1:0]  report_frame_o;

  per_source_sequence_loss_tracker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .source_addr_i     (source_addr_i),
    .peer_addr_i       (peer_addr_i),
    .packet_number_i   (packet_number_i),
    .link_qualifies_i  (link_qualifies_i),
    .frame_number_i    (frame_number_i),
    .done_o            (done_o),
    .peer_known_o      (peer_known_o),
    .table_full_o      (table_full_o),
    .number_advanced_o (number_advanced_o),
    .loss_found_o      (loss_found_o),
    .reporter_addr_o   (reporter_addr_o),
    .lost_from_addr_o  (lost_from_addr_o),
    .missed_number_o   (missed_number_o),
    .report_frame_o    (report_frame_o)
  );

  // Command stream, expected reports, error count
  tracker_cmd_t  cmd_queue[$];
  loss_report_t  report_queue[$];
  tracker_cmd_t  cur_cmd;
  loss_report_t  want;
  int unsigned   total_cmds;
  int unsigned   accepted;
  int unsigned   idle_left;
  int unsigned   mismatches;
  int unsigned   cycles;
  bit            taken;

  // Model of the source table
  logic [ADDR_W-1:0] held_addr[ENTRIES];
  logic [NUM_W-1:0]  held_num[ENTRIES];
  int unsigned       held;

  // Stimulus-side view of the sources in play
  logic [ADDR_W-1:0] pool_addr[POOL];
  logic [NUM_W-1:0]  pool_num[POOL];

  // Next report of the tracker for one command; updates the table model
  function automatic loss_report_t predict_report(tracker_cmd_t c);
    loss_report_t      r;
    logic [ADDR_W-1:0] key;
    logic [NUM_W-1:0]  ahead;
    int                hit;
    r   = '0;
    hit = -1;
    key = (c.command == CMD_UPDATE) ? c.source_addr : c.peer_addr;
    for (int i = 0; i < held; i++)
      if (hit < 0 && held_addr[i] == key) hit = i;
    if (c.command == CMD_UPDATE) begin
      if (hit >= 0) begin
        r.known = 1'b1;
        // serial arithmetic: ahead when the 8-bit difference is positive
        ahead = c.number - held_num[hit];
        if (ahead != '0 && !ahead[NUM_W-1]) begin
          held_num[hit] = c.number;
          r.advanced    = 1'b1;
        end
      end else if (held < ENTRIES) begin
        held_addr[held] = c.source_addr;
        held_num[held]  = c.number;
        held++;
        r.advanced = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end else if (hit >= 0) begin
      r.known = 1'b1;
      if (c.peer_addr != c.source_addr && c.link && c.number != held_num[hit]) begin
        r.loss      = 1'b1;
        r.reporter  = c.source_addr;
        r.lost_from = c.peer_addr;
        r.missed    = c.number + 1'b1;
        r.frame     = c.frame;
      end
    end
    return r;
  endfunction

  function automatic tracker_cmd_t make_update(logic [ADDR_W-1:0] src, logic [NUM_W-1:0] num);
    tracker_cmd_t c;
    c             = '0;
    c.command     = CMD_UPDATE;
    c.source_addr = src;
    c.number      = num;
    c.peer_addr   = ADDR_W'($urandom);
    c.link        = 1'($urandom_range(0, 1));
    c.frame       = FRAME_W'($urandom);
    return c;
  endfunction

  function automatic tracker_cmd_t make_check(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] peer,
                                              logic [NUM_W-1:0] num, logic link,
                                              logic [FRAME_W-1:0] frame);
    tracker_cmd_t c;
    c.command     = CMD_CHECK;
    c.source_addr = src;
    c.peer_addr   = peer;
    c.number      = num;
    c.link        = link;
    c.frame       = frame;
    return c;
  endfunction

  // Random traffic: mostly in-order updates and matching beacons over the pool
  task automatic queue_random_traffic(int unsigned n);
    int unsigned       s;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] peer;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  d;
    int unsigned       roll;
    for (int k = 0; k < n; k++) begin
      s    = $urandom_range(0, POOL - 1);
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd_queue.push_back(make_update(ADDR_W'($urandom), NUM_W'($urandom)));
        end else begin
          if (roll < 70)      num = pool_num[s] + NUM_W'($urandom_range(1, 3));
          else if (roll < 85) num = pool_num[s] - NUM_W'($urandom_range(0, 3));
          else                num = NUM_W'($urandom);
          d = num - pool_num[s];
          if (d != '0 && !d[NUM_W-1]) pool_num[s] = num;
          cmd_queue.push_back(make_update(pool_addr[s], num));
        end
      end else begin
        peer = ($urandom_range(0, 99) < 85) ? pool_addr[s] : ADDR_W'($urandom);
        src  = ($urandom_range(0, 1) == 0) ? pool_addr[$urandom_range(0, POOL - 1)]
                                           : ADDR_W'($urandom);
        if ($urandom_range(0, 19) == 0) src = peer;
        if (roll < 50)      num = pool_num[s];
        else if (roll < 80) num = pool_num[s] - NUM_W'($urandom_range(1, 5));
        else                num = NUM_W'($urandom);
        cmd_queue.push_back(make_check(src, peer, num, $urandom_range(0, 6) != 0,
                                       FRAME_W'($urandom)));
      end
    end
  endtask

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents queued commands, inserting idle bursts between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        report_queue.push_back(predict_report(cur_cmd));
        accepted++;
      end
      if (!start || taken) begin
        if (idle_left > 0) begin
          idle_left        <= idle_left - 1;
          start            <= 1'b0;
          command_i        <= 1'($urandom_range(0, 1));
          source_addr_i    <= ADDR_W'($urandom);
          peer_addr_i      <= ADDR_W'($urandom);
          packet_number_i  <= NUM_W'($urandom);
          link_qualifies_i <= 1'($urandom_range(0, 1));
          frame_number_i   <= FRAME_W'($urandom);
        end else if (cmd_queue.size() > 0) begin
          cur_cmd           = cmd_queue.pop_front();
          start            <= 1'b1;
          command_i        <= cur_cmd.command;
          source_addr_i    <= cur_cmd.source_addr;
          peer_addr_i      <= cur_cmd.peer_addr;
          packet_number_i  <= cur_cmd.number;
          link_qualifies_i <= cur_cmd.link;
          frame_number_i   <= cur_cmd.frame;
          // bursty gaps, then a calm tail at full rate
          if (cmd_queue.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
            idle_left <= $urandom_range(1, 17);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Monitor: each strobed result must match the oldest expected report
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (report_queue.size() == 0) begin
        $display("%0t: result transfer with no command outstanding", $time);
        mismatches++;
      end else begin
        want = report_queue.pop_front();
        compare_field("peer_known", 32'(want.known), 32'(peer_known_o));
        compare_field("table_full", 32'(want.full), 32'(table_full_o));
        compare_field("number_advanced", 32'(want.advanced), 32'(number_advanced_o));
        compare_field("loss_found", 32'(want.loss), 32'(loss_found_o));
        compare_field("reporter_addr", 32'(want.reporter), 32'(reporter_addr_o));
        compare_field("lost_from_addr", 32'(want.lost_from), 32'(lost_from_addr_o));
        compare_field("missed_number", 32'(want.missed), 32'(missed_number_o));
        compare_field("report_frame", 32'(want.frame), 32'(report_frame_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("per_source_sequence_loss_tracker_test: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    // first inserts, wrap, equal, half-range and stale updates
    cmd_queue.push_back(make_update(16'h0000, 8'h00));
    cmd_queue.push_back(make_update(16'hFFFF, 8'hFF));
    cmd_queue.push_back(make_update(16'h0000, 8'h00));
    cmd_queue.push_back(make_update(16'h0000, 8'h80));
    cmd_queue.push_back(make_update(16'h0000, 8'h7F));
    cmd_queue.push_back(make_update(16'h0000, 8'h10));
    cmd_queue.push_back(make_update(16'hFFFF, 8'h00));
    // beacon checks: no gap, gap with wrap, link not checked, self, unknown
    cmd_queue.push_back(make_check(16'h1234, 16'h0000, 8'h7F, 1'b1, 16'hFFFF));
    cmd_queue.push_back(make_check(16'h1234, 16'h0000, 8'hFF, 1'b1, 16'hFFFF));
    cmd_queue.push_back(make_check(16'hFFFF, 16'h0000, 8'h00, 1'b1, 16'h0000));
    cmd_queue.push_back(make_check(16'h5A5A, 16'hFFFF, 8'h01, 1'b0, 16'hA5A5));
    cmd_queue.push_back(make_check(16'hFFFF, 16'hFFFF, 8'h80, 1'b1, 16'h5A5A));
    cmd_queue.push_back(make_check(16'h0000, 16'hABCD, 8'h42, 1'b1, 16'h1111));
    cmd_queue.push_back(make_check(16'h0000, 16'hFFFF, 8'h7F, 1'b1, 16'h8000));

    // distinct pool of sources; the first two are already in the table
    pool_addr[0] = 16'h0000;
    pool_num[0]  = 8'h7F;
    pool_addr[1] = 16'hFFFF;
    pool_num[1]  = 8'h00;
    for (int i = 2; i < POOL; i++) begin
      pool_addr[i] = ADDR_W'($urandom);
      for (int j = 0; j < i; j++)
        if (pool_addr[j] == pool_addr[i]) begin
          pool_addr[i] = ADDR_W'($urandom);
          j = -1;
        end
      pool_num[i] = NUM_W'($urandom);
    end
    queue_random_traffic(RAND_ITEMS);
    total_cmds = cmd_queue.size();

    wait (accepted == total_cmds);
    wait (report_queue.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("per_source_sequence_loss_tracker_test: done, clean");
    else
      $display("per_source_sequence_loss_tracker_test: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/pst_pkg.sv
sv/pst_table.sv
sv/per_source_sequence_loss_tracker.sv
tb/per_source_sequence_loss_tracker_test.sv
